// ===== hdl/ntc_pkg.sv =====
// ntc_pkg: types and constants shared by the nearest-target-in-cone block.
// Depends on nothing; every module of the block imports it.
package ntc_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = $clog2(MaxPoints + 1);
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_DISABLE = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] tag;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [47:0]        min_dist_sq;
    logic [47:0]        max_dist_sq;
    logic signed [15:0] cone_cos;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [7:0]         slot;
    logic signed [15:0] found_tag;
    logic signed [23:0] found_x;
    logic signed [23:0] found_y;
    logic signed [23:0] found_z;
    logic [8:0]         point_count;
    logic               table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_DONE
  } exec_state_t;

endpackage

// ===== hdl/ntc_front.sv =====
// ntc_front: input queue that accepts and buffers items ahead of the executor.
// Depends on ntc_pkg.
module ntc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  ntc_pkg::in_item_t in_item,
  output logic              q_valid,
  input  logic              q_take,
  output ntc_pkg::in_item_t q_item
);
  import ntc_pkg::*;

  in_item_t   mem [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       do_push;
  logic       do_pop;

  assign full    = (used == 2'(QueueDepth));
  assign q_valid = (used != 2'd0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      used <= used + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

// ===== hdl/ntc_eval.sv =====
// ntc_eval: pipelined distance, range and cone test for one stored point.
// Depends on ntc_pkg. Five register stages; one point enters per cycle.
module ntc_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_idx,
  input  logic               in_enabled,
  input  logic signed [23:0] px,
  input  logic signed [23:0] py,
  input  logic signed [23:0] pz,
  input  ntc_pkg::in_item_t  q,
  output logic               out_valid,
  output logic               out_pass,
  output logic [47:0]        out_dist,
  output logic [7:0]         out_idx,
  output logic               busy
);
  import ntc_pkg::*;

  // stage 1: offsets
  logic               v1, en1;
  logic [7:0]         i1;
  logic signed [24:0] dx, dy, dz;
  // stage 2: squares and dot terms
  logic               v2, en2;
  logic [7:0]         i2;
  logic [49:0]        sx, sy, sz;
  logic signed [41:0] tx, ty, tz;
  // stage 3: sums and range test
  logic               v3, ok3;
  logic [7:0]         i3;
  logic [51:0]        s3;
  logic [47:0]        sat3;
  logic signed [43:0] d3;
  logic [31:0]        cc3;
  // stage 4: partial products of the cone terms
  logic               v4, ok4, dneg4, sz4;
  logic [7:0]         i4;
  logic [47:0]        sat4;
  logic [43:0]        pp_hh, pp_hl, pp_ll;
  logic [57:0]        pc_h, pc_l;
  // stage 5: full cone products
  logic               v5, ok5, dneg5, sz5;
  logic [7:0]         i5;
  logic [47:0]        sat5;
  logic [87:0]        dd5;
  logic [83:0]        cs5;

  logic [51:0]        s_sum;
  logic signed [43:0] d_sum;
  logic [43:0]        dmag;
  logic [15:0]        cmag;
  logic               cpos, cneg, cone_ok;

  assign s_sum = 52'(sx) + 52'(sy) + 52'(sz);
  assign d_sum = 44'(tx) + 44'(ty) + 44'(tz);
  assign dmag  = d3[43] ? 44'(-d3) : 44'(d3);
  assign cmag  = q.cone_cos[15] ? 16'(-q.cone_cos) : 16'(q.cone_cos);
  assign cpos  = !q.cone_cos[15] && (q.cone_cos != 16'sd0);
  assign cneg  = q.cone_cos[15];

  always_ff @(posedge clk) begin
    dx  <= 25'(px) - 25'(q.pos_x);
    dy  <= 25'(py) - 25'(q.pos_y);
    dz  <= 25'(pz) - 25'(q.pos_z);
    en1 <= in_enabled;
    i1  <= in_idx;
    sx  <= 50'(dx * dx);
    sy  <= 50'(dy * dy);
    sz  <= 50'(dz * dz);
    tx  <= 42'(dx * q.dir_x);
    ty  <= 42'(dy * q.dir_y);
    tz  <= 42'(dz * q.dir_z);
    en2 <= en1;
    i2  <= i1;
    s3   <= s_sum;
    sat3 <= (s_sum[51:48] != 4'd0) ? '1 : s_sum[47:0];
    d3   <= d_sum;
    cc3  <= 32'(cmag) * 32'(cmag);
    ok3  <= en2 && ((s_sum[51:48] != 4'd0) ? 1'b1 : (s_sum[47:0] >= q.min_dist_sq))
            && (((s_sum[51:48] != 4'd0) ? 48'hFFFF_FFFF_FFFF : s_sum[47:0])
                <= q.max_dist_sq);
    i3   <= i2;
    // split the wide products into halves
    pp_hh <= 44'(dmag[43:22]) * 44'(dmag[43:22]);
    pp_hl <= 44'(dmag[43:22]) * 44'(dmag[21:0]);
    pp_ll <= 44'(dmag[21:0]) * 44'(dmag[21:0]);
    pc_h  <= 58'(cc3) * 58'(s3[51:26]);
    pc_l  <= 58'(cc3) * 58'(s3[25:0]);
    dneg4 <= d3[43];
    sz4   <= (s3 == 52'd0);
    ok4   <= ok3;
    sat4  <= sat3;
    i4    <= i3;
    dd5   <= (88'(pp_hh) << 44) + (88'(pp_hl) << 23) + 88'(pp_ll);
    cs5   <= (84'(pc_h) << 26) + 84'(pc_l);
    dneg5 <= dneg4;
    sz5   <= sz4;
    ok5   <= ok4;
    sat5  <= sat4;
    i5    <= i4;
  end

  always_comb begin
    if (sz5) cone_ok = !cpos;
    else if (!dneg5) cone_ok = !cpos || (dd5 >= 88'(cs5));
    else cone_ok = cneg && (dd5 <= 88'(cs5));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  assign out_valid = v5;
  assign out_pass  = ok5 && cone_ok;
  assign out_dist  = sat5;
  assign out_idx   = i5;
  assign busy      = v1 || v2 || v3 || v4 || v5;
endmodule

// ===== hdl/ntc_back.sv =====
// ntc_back: point table and sequencer that carries out one item at a time.
// Depends on ntc_pkg and ntc_eval.
module ntc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_take,
  input  ntc_pkg::in_item_t  q_item,
  output logic               empty,
  input  logic               pop,
  output ntc_pkg::out_item_t res
);
  import ntc_pkg::*;

  logic [23:0] mem_x [MaxPoints];
  logic [23:0] mem_y [MaxPoints];
  logic [23:0] mem_z [MaxPoints];
  logic [15:0] mem_t [MaxPoints];
  logic        mem_e [MaxPoints];

  exec_state_t state, state_next;
  in_item_t    cur;
  logic [CountW-1:0] count;
  logic [CountW-1:0] idx;
  logic        rd_valid;
  logic [7:0]  rd_idx;
  logic [AddrW-1:0] rd_addr;
  logic [23:0] rx, ry, rz;
  logic [15:0] rt;
  logic        re;
  logic        have;
  logic [47:0] best;
  logic [7:0]  best_idx;
  logic        res_valid;
  logic        refused;
  logic        ev_valid, ev_pass, ev_busy;
  logic [47:0] ev_dist;
  logic [7:0]  ev_idx;
  logic        issue;
  logic        out_free;

  assign out_free = !res_valid || pop;
  assign empty    = !res_valid;
  assign q_take   = (state == ST_IDLE) && q_valid;
  assign issue    = (state == ST_SCAN) && (idx < count);
  // hold the winning slot on the read port from fetch until the result is written
  assign rd_addr  = ((state == ST_FETCH) || (state == ST_FETCH_WAIT) || (state == ST_DONE))
                    ? best_idx : idx[AddrW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (q_valid) begin
        state_next = ((q_item.kind == KIND_QUERY) || (q_item.kind == KIND_DISABLE))
                     ? ST_SCAN : ST_DONE;
      end
      ST_SCAN:       if (idx >= count) state_next = ST_DRAIN;
      ST_DRAIN:      if (!rd_valid && !ev_busy) begin
        state_next = (cur.kind == KIND_QUERY && have) ? ST_FETCH : ST_DONE;
      end
      ST_FETCH:      state_next = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_next = ST_DONE;
      ST_DONE:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.kind == KIND_APPEND &&
        count < CountW'(MaxPoints)) begin
      mem_x[count[AddrW-1:0]] <= q_item.pos_x;
      mem_y[count[AddrW-1:0]] <= q_item.pos_y;
      mem_z[count[AddrW-1:0]] <= q_item.pos_z;
      mem_t[count[AddrW-1:0]] <= q_item.tag;
    end
    rx <= mem_x[rd_addr];
    ry <= mem_y[rd_addr];
    rz <= mem_z[rd_addr];
    rt <= mem_t[rd_addr];
    rd_idx <= idx[7:0];
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.kind == KIND_APPEND &&
        count < CountW'(MaxPoints)) begin
      mem_e[count[AddrW-1:0]] <= 1'b1;
    end else if (rd_valid && cur.kind == KIND_DISABLE && rt == cur.tag) begin
      mem_e[rd_idx] <= 1'b0;
    end
    re <= mem_e[idx[AddrW-1:0]];
  end

  ntc_eval u_eval (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rd_valid && cur.kind == KIND_QUERY),
    .in_idx     (rd_idx),
    .in_enabled (re),
    .px         (rx),
    .py         (ry),
    .pz         (rz),
    .q          (cur),
    .out_valid  (ev_valid),
    .out_pass   (ev_pass),
    .out_dist   (ev_dist),
    .out_idx    (ev_idx),
    .busy       (ev_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      have      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) idx <= idx + 1'b1;
      res_valid <= ((state == ST_DONE) && out_free) || (res_valid && !pop);
      case (state)
        ST_IDLE: if (q_valid) begin
          cur  <= q_item;
          idx  <= '0;
          have <= 1'b0;
          if (q_item.kind == KIND_CLEAR) count <= '0;
          else if (q_item.kind == KIND_APPEND && count < CountW'(MaxPoints)) begin
            count <= count + 1'b1;
          end
          refused <= (q_item.kind == KIND_APPEND) && (count == CountW'(MaxPoints));
        end
        ST_DONE: if (out_free) begin
          res.table_full  <= refused;
          res.point_count <= 9'(count);
          res.found       <= (cur.kind == KIND_QUERY) && have;
          res.slot        <= ((cur.kind == KIND_QUERY) && have) ? best_idx : 8'd0;
          res.found_tag   <= ((cur.kind == KIND_QUERY) && have) ? rt : 16'hFFFF;
          res.found_x     <= ((cur.kind == KIND_QUERY) && have) ? rx : 24'd0;
          res.found_y     <= ((cur.kind == KIND_QUERY) && have) ? ry : 24'd0;
          res.found_z     <= ((cur.kind == KIND_QUERY) && have) ? rz : 24'd0;
        end
        default: ;
      endcase
      // track nearest passing point; strict compare keeps the lowest slot
      if (ev_valid && ev_pass && (!have || ev_dist < best)) begin
        have     <= 1'b1;
        best     <= ev_dist;
        best_idx <= ev_idx;
      end
    end
  end
endmodule

// ===== hdl/nearest_target_in_cone.sv =====
// nearest_target_in_cone: nearest enabled target inside a range shell and a view cone.
// Append and clear update the table and go straight to the result; disable and query
// walk the table one point per cycle, and a query runs each point through the
// five-stage test pipeline and on a hit fetches the winning point. One item at a time:
// nothing new is taken until the result is registered; a two-entry input queue and a
// result register decouple the ports. Reset (rst, synchronous) empties table and queues.
module nearest_target_in_cone (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  ntc_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output ntc_pkg::out_item_t out_item
);
  import ntc_pkg::*;

  logic     q_valid;
  logic     q_take;
  in_item_t q_item;

  // Hold incoming items until the executor is free.
  ntc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item)
  );

  // Execute: table update, or a walk over all stored points.
  ntc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item),
    .empty   (empty),
    .pop     (pop),
    .res     (out_item)
  );
endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for nearest_target_in_cone (queue-style ports).
// Depends on ntc_pkg and the nearest_target_in_cone RTL; holds its own table predictor.
module tb;
  import ntc_pkg::*;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;

  nearest_target_in_cone dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  // Clock with a period of 2 time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the target table, updated as each item is accepted.
  logic signed [23:0] tbl_x [MaxPoints];
  logic signed [23:0] tbl_y [MaxPoints];
  logic signed [23:0] tbl_z [MaxPoints];
  logic signed [15:0] tbl_tag [MaxPoints];
  logic               tbl_on [MaxPoints];
  int                 tbl_count;

  out_item_t expected_results[$];
  int        fail_count;
  int        checked_count;
  int        found_count;
  int        refused_count;
  bit        hold_pop;      // receiver long hold-off request
  int        hold_cycles;

  // Cone test: dot >= c * sqrt(s), done without a root and with signs respected.
  function automatic bit cone_pass(longint dot, longint c, longint unsigned s);
    logic [127:0] lhs;
    logic [127:0] rhs;
    longint unsigned dm;
    longint unsigned cm;
    if (s == 0) return c <= 0;
    dm = (dot < 0) ? -dot : dot;
    cm = (c < 0) ? -c : c;
    lhs = 128'(dm) * 128'(dm);
    rhs = 128'(cm * cm) * 128'(s);
    if (dot >= 0) begin
      if (c <= 0) return 1'b1;
      return lhs >= rhs;
    end
    if (c >= 0) return 1'b0;
    return lhs <= rhs;
  endfunction

  // Apply one item to the shadow table and return the result it must produce.
  function automatic out_item_t predict_target(in_item_t it);
    out_item_t r;
    longint dx, dy, dz, dot;
    longint unsigned s, sat, best;
    bit have;
    int bi;
    r = '0;
    r.found_tag = -16'sd1;
    have = 1'b0;
    best = 0;
    bi = 0;
    case (kind_t'(it.kind))
      KIND_APPEND: begin
        if (tbl_count < MaxPoints) begin
          tbl_x[tbl_count] = it.pos_x;
          tbl_y[tbl_count] = it.pos_y;
          tbl_z[tbl_count] = it.pos_z;
          tbl_tag[tbl_count] = it.tag;
          tbl_on[tbl_count] = 1'b1;
          tbl_count++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      KIND_CLEAR: tbl_count = 0;
      KIND_DISABLE: begin
        for (int i = 0; i < tbl_count; i++)
          if (tbl_tag[i] == it.tag) tbl_on[i] = 1'b0;
      end
      default: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_on[i]) continue;
          dx = longint'(tbl_x[i]) - longint'(it.pos_x);
          dy = longint'(tbl_y[i]) - longint'(it.pos_y);
          dz = longint'(tbl_z[i]) - longint'(it.pos_z);
          s = dx * dx + dy * dy + dz * dz;
          sat = (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
          if (sat < it.min_dist_sq || sat > it.max_dist_sq) continue;
          dot = longint'(it.dir_x) * dx + longint'(it.dir_y) * dy + longint'(it.dir_z) * dz;
          if (!cone_pass(dot, longint'(it.cone_cos), s)) continue;
          if (!have || sat < best) begin
            have = 1'b1;
            best = sat;
            bi = i;
          end
        end
        if (have) begin
          r.found = 1'b1;
          r.slot = bi[7:0];
          r.found_tag = tbl_tag[bi];
          r.found_x = tbl_x[bi];
          r.found_y = tbl_y[bi];
          r.found_z = tbl_z[bi];
        end
      end
    endcase
    r.point_count = tbl_count[8:0];
    return r;
  endfunction

  // Offer one item after a random gap; hold push until the block takes it.
  // Push stays high into the next call so back-to-back items need no extra edge.
  task automatic send_item(in_item_t it, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_results.push_back(predict_target(it));
  endtask

  // Drop push, then wait until every expected result has come back.
  task automatic drain_results();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t blank_item(kind_t k);
    in_item_t it;
    it = '0;
    it.kind = k;
    it.tag = -16'sd1;
    return it;
  endfunction

  function automatic logic [15:0] rand_dir();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // Random item; positions mostly from a small grid so that hits are common.
  function automatic in_item_t rand_item(kind_t k, bit wide);
    in_item_t it;
    it = blank_item(k);
    if (wide) begin
      it.pos_x = 24'($urandom); it.pos_y = 24'($urandom); it.pos_z = 24'($urandom);
    end else begin
      it.pos_x = 24'($signed($urandom_range(0, 64)) - 32) <<< 10;
      it.pos_y = 24'($signed($urandom_range(0, 64)) - 32) <<< 10;
      it.pos_z = 24'($signed($urandom_range(0, 64)) - 32) <<< 10;
    end
    it.tag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
    it.dir_x = rand_dir(); it.dir_y = rand_dir(); it.dir_z = rand_dir();
    if ($urandom_range(0, 19) == 0) it.dir_x = 16'($urandom);
    it.cone_cos = ($urandom_range(0, 19) == 0) ? 16'($urandom) : rand_dir();
    it.min_dist_sq = ($urandom_range(0, 2) == 0) ? 48'({$urandom, $urandom}) >> $urandom_range(0, 47) : '0;
    it.max_dist_sq = ($urandom_range(0, 2) == 0) ? 48'({$urandom, $urandom}) >> $urandom_range(0, 47)
                                                : 48'hFFFF_FFFF_FFFF;
    return it;
  endfunction

  // Receiver: random pop gaps, plus a long hold when requested.
  initial begin
    int gap;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_pop = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        fail_count++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        checked_count++;
        if (e.found) found_count++;
        if (e.table_full) refused_count++;
        if (out_item.found !== e.found)
          $display("%0t: found exp %0d got %0d", $time, e.found, out_item.found);
        if (out_item.slot !== e.slot)
          $display("%0t: slot exp %0d got %0d", $time, e.slot, out_item.slot);
        if (out_item.found_tag !== e.found_tag)
          $display("%0t: tag exp %0d got %0d", $time, e.found_tag, out_item.found_tag);
        if (out_item.found_x !== e.found_x)
          $display("%0t: x exp %h got %h", $time, e.found_x, out_item.found_x);
        if (out_item.found_y !== e.found_y)
          $display("%0t: y exp %h got %h", $time, e.found_y, out_item.found_y);
        if (out_item.found_z !== e.found_z)
          $display("%0t: z exp %h got %h", $time, e.found_z, out_item.found_z);
        if (out_item.point_count !== e.point_count)
          $display("%0t: count exp %0d got %0d", $time, e.point_count, out_item.point_count);
        if (out_item.table_full !== e.table_full)
          $display("%0t: full exp %0d got %0d", $time, e.table_full, out_item.table_full);
        if (out_item !== e) fail_count++;
      end
    end
  end

  // Directed: field extremes, every kind, zero offset, min above max, odd direction.
  task automatic test_directed();
    in_item_t it;
    send_item(blank_item(KIND_QUERY));           // empty table query
    it = blank_item(KIND_APPEND);
    it.pos_x = 24'h7FFFFF; it.pos_y = 24'h800000; it.pos_z = 24'h7FFFFF; it.tag = 16'sh7FFF;
    send_item(it);
    it.pos_x = 24'h800000; it.pos_y = 24'h7FFFFF; it.pos_z = 24'h800000; it.tag = -16'sd32768;
    send_item(it);
    it.pos_x = 0; it.pos_y = 0; it.pos_z = 0; it.tag = -16'sd1;
    send_item(it);
    it = blank_item(KIND_QUERY);                 // zero offset, cone_cos 0 passes
    it.max_dist_sq = '1;
    send_item(it);
    it.cone_cos = 16'sd1;                        // zero offset now fails
    send_item(it);
    it.cone_cos = -16'sd16384; it.pos_x = 24'h800000; it.pos_y = 24'h800000;
    it.pos_z = 24'h800000;                       // saturating distances
    send_item(it);
    it.min_dist_sq = '1; it.max_dist_sq = 0;     // min above max
    send_item(it);
    it = blank_item(KIND_QUERY);
    it.max_dist_sq = '1; it.dir_x = 16'sh7FFF; it.dir_y = 16'sh8000; it.dir_z = 16'sd16384;
    it.cone_cos = 16'sh8000;
    send_item(it);
    it.cone_cos = 16'sh7FFF; it.dir_x = 16'sd16384; it.dir_y = 0; it.dir_z = 0;
    send_item(it);
    it = blank_item(KIND_DISABLE); it.tag = -16'sd1;
    send_item(it);
    it.tag = 16'sh7FFF;
    send_item(it);
    it = blank_item(KIND_QUERY); it.max_dist_sq = '1; it.cone_cos = -16'sd16384;
    send_item(it);
    send_item(blank_item(KIND_CLEAR));
    send_item(it);
    drain_results();
  endtask

  // Fill the table to the top, starting while the receiver is held off, then refuse appends.
  task automatic test_fill_and_overflow();
    hold_cycles = 300;
    hold_pop = 1'b1;
    for (int i = 0; i < MaxPoints + 3; i++)
      send_item(rand_item(KIND_APPEND, $urandom_range(0, 7) == 0), 1'b1);
    for (int i = 0; i < 6; i++)
      send_item(rand_item(KIND_QUERY, 1'b0));
    // Sender pauses until every result is back.
    drain_results();
    send_item(blank_item(KIND_CLEAR));
    drain_results();
  endtask

  // Random phases: small tables built then queried, with disables and noise.
  task automatic test_random_mix(int n_items);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) send_item(rand_item(KIND_APPEND, $urandom_range(0, 9) == 0));
      else if (r < 37) send_item(rand_item(KIND_CLEAR, 1'b1));
      else if (r < 45) send_item(rand_item(KIND_DISABLE, 1'b0));
      else send_item(rand_item(KIND_QUERY, $urandom_range(0, 9) == 0));
      if (tbl_count > 40 && $urandom_range(0, 9) == 0) send_item(blank_item(KIND_CLEAR));
    end
    drain_results();
  endtask

  initial begin
    fail_count = 0;
    checked_count = 0;
    found_count = 0;
    refused_count = 0;
    hold_pop = 1'b0;
    hold_cycles = 0;
    tbl_count = 0;
    push <= 1'b0;
    in_item <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_overflow();
    test_random_mix(1650);
    repeat (300) @(posedge clk);
    $display("Checked %0d results: %0d queries hit, %0d appends refused on a full table.",
             checked_count, found_count, refused_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS nearest_target_in_cone");
    end else begin
      $display("FAIL nearest_target_in_cone");
    end
    $finish;
  end

  // Watchdog: generous bound over the slowest correct run.
  initial begin
    #4000000;
    $display("FAIL nearest_target_in_cone");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ntc_pkg.sv
hdl/ntc_front.sv
hdl/ntc_eval.sv
hdl/ntc_back.sv
hdl/nearest_target_in_cone.sv
tb/sv/tb.sv
